// ===== rtl/pli_pkg.sv =====
// Shared types, constants and helpers for the particle leapfrog integrator.
// No dependencies; every other source file except pli_stream_if imports this package.
package pli_pkg;

  localparam int DIV_LAT   = 48;  // quotient bits, one per divider stage
  localparam int LANES     = 3;   // x, y, rotation
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [16:0] DAMP_ONE = 17'd65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET   = 3'd4;

  localparam logic [15:0] DAMPING_RST = 16'd0;
  localparam logic [31:0] DT_RST      = 32'd65;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] torque_in;
    logic [31:0]        body_mass;
    logic [31:0]        inertia_in;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] ang_vel_in;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle_in;
    logic [3:0]         dof_flags;
  } body_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_ang_vel;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_angle;
  } result_t;

  // saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

// ===== rtl/pli_stream_if.sv =====
// Valid/ready stream channel carrying one payload of type T.
// Depends on nothing; payload types come from pli_pkg.
interface pli_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pli_div.sv =====
// Pipelined signed Q16.16 divider, one quotient bit per stage, saturating.
// Depends on pli_pkg.
module pli_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output logic signed [31:0] quo
);
  import pli_pkg::*;

  localparam int L = DIV_LAT;

  logic [L-1:0]  dvd  [L];
  logic [31:0]   rem  [L];
  logic [L-1:0]  qt   [L];
  logic [31:0]   dn   [L];
  logic          neg  [L];
  logic          zero [L];

  logic [L-1:0]  dvd_next [L];
  logic [31:0]   rem_next [L];
  logic [L-1:0]  qt_next  [L];

  logic [31:0]   mag;
  logic [L-1:0]  src_dvd;
  logic [31:0]   src_rem;
  logic [L-1:0]  src_qt;
  logic [31:0]   src_dn;
  logic [32:0]   trial;

  assign mag = num[31] ? 32'(-num) : num;

  // one restoring step per stage
  always_comb begin
    for (int i = 0; i < L; i++) begin
      if (i == 0) begin
        src_dvd = {mag, 16'd0};
        src_rem = '0;
        src_qt  = '0;
        src_dn  = den;
      end else begin
        src_dvd = dvd[i-1];
        src_rem = rem[i-1];
        src_qt  = qt[i-1];
        src_dn  = dn[i-1];
      end
      trial = {src_rem, src_dvd[L-1]};
      dvd_next[i] = {src_dvd[L-2:0], 1'b0};
      if (trial >= {1'b0, src_dn}) begin
        rem_next[i] = 32'(trial - {1'b0, src_dn});
        qt_next[i]  = {src_qt[L-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[31:0];
        qt_next[i]  = {src_qt[L-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        dvd[i] <= dvd_next[i];
        rem[i] <= rem_next[i];
        qt[i]  <= qt_next[i];
        if (i == 0) begin
          dn[i]   <= den;
          neg[i]  <= num[31];
          zero[i] <= (num == 0);
        end else begin
          dn[i]   <= dn[i-1];
          neg[i]  <= neg[i-1];
          zero[i] <= zero[i-1];
        end
      end
    end
  end

  // sign, zero numerator and overflow (division by zero gives all ones)
  always_comb begin
    if (zero[L-1]) quo = '0;
    else if (neg[L-1]) quo = sat32(-$signed({18'd0, qt[L-1]}));
    else quo = sat32($signed({18'd0, qt[L-1]}));
  end

endmodule

// ===== rtl/particle_leapfrog_integrator_core.sv =====
// Top level of the 2D leapfrog integrator with Cundall damping.
// Depends on pli_pkg, pli_stream_if and pli_div.

// One body enters per cycle unless the result side stalls; the depth is
// set by the three bit-per-stage quotient pipelines (force x, force y,
// torque) followed by seven stages of damping, velocity and position
// arithmetic. A stall on the result side freezes the whole pipeline;
// nothing is dropped or repeated.
module particle_leapfrog_integrator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pli_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pli_pkg::CFG_DATA_W-1:0]    cfg_data,
  pli_stream_if.sink                        body,
  pli_stream_if.source                      result
);
  import pli_pkg::*;

  typedef struct packed {
    logic [LANES-1:0][31:0] vel;
    logic [LANES-1:0][31:0] pos;
    logic [3:0]             flags;
  } carry_t;

  // configuration registers
  logic [15:0]        damping;
  logic [31:0]        dt;
  logic signed [31:0] gx;
  logic signed [31:0] gy;
  logic               quiet;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= DAMPING_RST;
      dt      <= DT_RST;
      gx      <= '0;
      gy      <= '0;
      quiet   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DAMPING: damping <= cfg_data[15:0];
        CFG_DT:      dt      <= cfg_data;
        CFG_GX:      gx      <= cfg_data;
        CFG_GY:      gy      <= cfg_data;
        CFG_QUIET:   quiet   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: whole pipeline moves unless the output is held
  logic adv;
  logic [DIV_LAT-1:0] dv;
  logic va, vb, vc, vd, ve, vf, vg;
  assign adv        = !vg || result.ready;
  assign body.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      {va, vb, vc, vd, ve, vf, vg} <= '0;
    end else if (adv) begin
      dv <= {dv[DIV_LAT-2:0], body.valid};
      {va, vb, vc, vd, ve, vf, vg} <= {dv[DIV_LAT-1], va, vb, vc, vd, ve, vf};
    end
  end

  // dividers
  logic signed [31:0] quo [LANES];
  pli_div u_div_x (.clk, .en(adv), .num(body.data.force_x),
                   .den(body.data.body_mass), .quo(quo[0]));
  pli_div u_div_y (.clk, .en(adv), .num(body.data.force_y),
                   .den(body.data.body_mass), .quo(quo[1]));
  pli_div u_div_w (.clk, .en(adv), .num(body.data.torque_in),
                   .den(body.data.inertia_in), .quo(quo[2]));

  // payload delay line matching divider latency
  carry_t dl [DIV_LAT];
  carry_t c_in;
  assign c_in.vel   = {body.data.ang_vel_in, body.data.vel_y, body.data.vel_x};
  assign c_in.pos   = {body.data.angle_in, body.data.pos_y, body.data.pos_x};
  assign c_in.flags = body.data.dof_flags;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl[i] <= (i == 0) ? c_in : dl[i-1];
      end
    end
  end

  // stage registers
  carry_t ca, cb, cc, cd, ce, cf;
  logic signed [31:0] a_a   [LANES];
  logic signed [31:0] a_b   [LANES];
  logic signed [64:0] h_b   [LANES];
  logic signed [49:0] p_c   [LANES];
  logic signed [31:0] a_c   [LANES];
  logic [LANES-1:0]   keep_c;
  logic signed [64:0] m_d   [LANES];
  logic signed [31:0] v_e   [LANES];
  logic signed [64:0] m_f   [LANES];
  logic signed [31:0] v_f   [LANES];
  result_t            res;

  logic signed [31:0] grav  [LANES];
  logic signed [65:0] t_sum [LANES];
  logic signed [31:0] a_d   [LANES];
  logic [16:0]        fac   [LANES];
  logic               sa_p, sa_n, st_p, st_n;
  logic signed [31:0] pos_g [LANES];
  logic signed [31:0] vel_g [LANES];

  assign grav[0] = gx;
  assign grav[1] = gy;
  assign grav[2] = '0;

  // damping factor choice from the sign of a*(v + a*dt/2)
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      t_sum[k] = 66'($signed(cb.vel[k])) + 66'(h_b[k] >>> 17);
      sa_p = !a_b[k][31] && (a_b[k] != 0);
      sa_n = a_b[k][31];
      st_p = !t_sum[k][65] && (t_sum[k] != 0);
      st_n = t_sum[k][65];
      fac[k] = DAMP_ONE;
      if ((sa_p && st_p) || (sa_n && st_n)) fac[k] = DAMP_ONE - {1'b0, damping};
      else if ((sa_p && st_n) || (sa_n && st_p)) fac[k] = DAMP_ONE + {1'b0, damping};
      a_d[k] = keep_c[k] ? a_c[k] : sat32(66'(p_c[k] >>> 16));
      pos_g[k] = quiet ? $signed(cf.pos[k])
               : sat32(66'($signed(cf.pos[k])) + 66'(m_f[k] >>> 16));
      vel_g[k] = quiet ? 32'sd0 : v_f[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca <= dl[DIV_LAT-1];
      cb <= ca;
      cc <= cb;
      cd <= cc;
      ce <= cd;
      cf <= ce;
      for (int k = 0; k < LANES; k++) begin
        // A: acceleration, blocked axis gives zero
        a_a[k] <= dl[DIV_LAT-1].flags[k] ? 32'sd0
                  : sat32(66'(quo[k]) + 66'(grav[k]));
        // B: half-step product
        a_b[k] <= a_a[k];
        h_b[k] <= $signed({1'b0, dt}) * a_a[k];
        // C: damping product
        a_c[k]    <= a_b[k];
        keep_c[k] <= !cb.flags[3];
        p_c[k]    <= a_b[k] * $signed({1'b0, fac[k]});
        // D: velocity increment
        m_d[k] <= $signed({1'b0, dt}) * a_d[k];
        // E: new velocity
        v_e[k] <= sat32(66'($signed(cd.vel[k])) + 66'(m_d[k] >>> 16));
        // F: position increment
        v_f[k] <= v_e[k];
        m_f[k] <= $signed({1'b0, dt}) * v_e[k];
      end
      // G: output register
      res.new_vel_x   <= vel_g[0];
      res.new_vel_y   <= vel_g[1];
      res.new_ang_vel <= vel_g[2];
      res.new_pos_x   <= pos_g[0];
      res.new_pos_y   <= pos_g[1];
      res.new_angle   <= pos_g[2];
    end
  end

  assign result.valid = vg;
  assign result.data  = res;

  // checks
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !body.ready |=> $stable({dv, va, vb, vc, vd, ve, vf, vg}))
    else $error("pipeline valid bits moved during a stall");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !body.ready)
    else $error("input taken while result held");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for particle_leapfrog_integrator_core.
// Depends on pli_pkg, pli_stream_if and the core; predicts every body update
// in Q16.16 and checks each result transaction against the oldest prediction.
module testbench;
  import pli_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DAMPING;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pli_stream_if #(.T(body_t)) body_ch ();
  pli_stream_if #(.T(result_t)) result_ch ();

  particle_leapfrog_integrator_core i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .body(body_ch),
    .result(result_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the configuration registers
  longint damping_sh = 0;
  longint dt_sh = 65;
  longint gx_sh = 0;
  longint gy_sh = 0;
  bit quiet_sh = 1'b0;

  body_t pending_bodies[$];
  result_t expected_updates[$];
  int errors = 0;
  int cyc = 0;

  initial begin
    body_ch.valid = 1'b0;
    body_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  // append one body to the stimulus queue
  function automatic void queue_body(body_t b);
    pending_bodies.insert(pending_bodies.size(), b);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Q16.16 quotient, truncated, saturating on divide by zero
  function automatic longint quot(longint num, longint den);
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    return clamp32((num * 65536) / den);
  endfunction

  function automatic int sgn(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  // second-order damping of acceleration a against velocity v
  function automatic longint cundall(longint a, longint v);
    longint half;
    int s;
    half = (dt_sh * a) >>> 17;
    s = sgn(a) * sgn(v + half);
    if (s > 0) return clamp32((a * (65536 - damping_sh)) >>> 16);
    if (s < 0) return clamp32((a * (65536 + damping_sh)) >>> 16);
    return a;
  endfunction

  function automatic longint step_by(longint base, longint rate);
    return clamp32(base + ((dt_sh * rate) >>> 16));
  endfunction

  function automatic result_t integrate(body_t b);
    longint ax, ay, aw, vx, vy, w, px, py, ang;
    result_t r;
    ax = 0;
    ay = 0;
    aw = 0;
    vx = longint'(b.vel_x);
    vy = longint'(b.vel_y);
    w = longint'(b.ang_vel_in);
    px = longint'(b.pos_x);
    py = longint'(b.pos_y);
    ang = longint'(b.angle_in);
    if (!b.dof_flags[0]) ax = clamp32(quot(longint'(b.force_x), longint'(b.body_mass)) + gx_sh);
    if (!b.dof_flags[1]) ay = clamp32(quot(longint'(b.force_y), longint'(b.body_mass)) + gy_sh);
    if (!b.dof_flags[2]) aw = quot(longint'(b.torque_in), longint'(b.inertia_in));
    if (b.dof_flags[3]) begin
      ax = cundall(ax, vx);
      ay = cundall(ay, vy);
      aw = cundall(aw, w);
    end
    vx = step_by(vx, ax);
    vy = step_by(vy, ay);
    w = step_by(w, aw);
    if (quiet_sh) begin
      vx = 0;
      vy = 0;
      w = 0;
    end else begin
      ang = step_by(ang, w);
      px = step_by(px, vx);
      py = step_by(py, vy);
    end
    r.new_vel_x = vx[31:0];
    r.new_vel_y = vy[31:0];
    r.new_ang_vel = w[31:0];
    r.new_pos_x = px[31:0];
    r.new_pos_y = py[31:0];
    r.new_angle = ang[31:0];
    return r;
  endfunction

  function automatic int span(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // mostly physical bodies, some raw noise with every bit random
  function automatic body_t random_body();
    body_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, 4'($urandom)};
    end else begin
      b.force_x = span(8000000);
      b.force_y = span(8000000);
      b.torque_in = span(8000000);
      b.body_mass = (pick < 25) ? 32'd0 : $urandom_range(4096, 6553600);
      b.inertia_in = (pick < 28) ? 32'd0 : $urandom_range(4096, 6553600);
      b.vel_x = span(6553600);
      b.vel_y = span(6553600);
      b.ang_vel_in = span(6553600);
      b.pos_x = $urandom;
      b.pos_y = span(60000000);
      b.angle_in = span(600000);
      b.dof_flags = 4'($urandom);
    end
    return b;
  endfunction

  function automatic body_t mk(int f, int m, int v, int p, logic [3:0] fl);
    body_t b;
    b.force_x = f;
    b.force_y = -f;
    b.torque_in = f;
    b.body_mass = m;
    b.inertia_in = m;
    b.vel_x = v;
    b.vel_y = -v;
    b.ang_vel_in = v;
    b.pos_x = p;
    b.pos_y = -p;
    b.angle_in = p;
    b.dof_flags = fl;
    return b;
  endfunction

  // driver: one body transaction per handshake, predicted when accepted
  always @(posedge clk) begin
    if (rst) begin
      body_ch.valid <= 1'b0;
    end else begin
      if (body_ch.valid && body_ch.ready)
        expected_updates.insert(expected_updates.size(), integrate(body_ch.data));
      if (!body_ch.valid || body_ch.ready) begin
        if (pending_bodies.size() != 0 &&
            ((cyc > 3000 && cyc < 3800) || $urandom_range(0, 99) >= 20)) begin
          body_ch.data <= pending_bodies.pop_front();
          body_ch.valid <= 1'b1;
        end else begin
          body_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and field-by-field check
  always @(posedge clk) begin
    result_t exp_r;
    cyc <= cyc + 1;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_updates.size() == 0) begin
          $error("unexpected result transaction %h", result_ch.data);
          errors++;
        end else begin
          exp_r = expected_updates.pop_front();
          if (result_ch.data.new_vel_x !== exp_r.new_vel_x) begin
            $error("new_vel_x exp %h got %h", exp_r.new_vel_x, result_ch.data.new_vel_x);
            errors++;
          end
          if (result_ch.data.new_vel_y !== exp_r.new_vel_y) begin
            $error("new_vel_y exp %h got %h", exp_r.new_vel_y, result_ch.data.new_vel_y);
            errors++;
          end
          if (result_ch.data.new_ang_vel !== exp_r.new_ang_vel) begin
            $error("new_ang_vel exp %h got %h", exp_r.new_ang_vel, result_ch.data.new_ang_vel);
            errors++;
          end
          if (result_ch.data.new_pos_x !== exp_r.new_pos_x) begin
            $error("new_pos_x exp %h got %h", exp_r.new_pos_x, result_ch.data.new_pos_x);
            errors++;
          end
          if (result_ch.data.new_pos_y !== exp_r.new_pos_y) begin
            $error("new_pos_y exp %h got %h", exp_r.new_pos_y, result_ch.data.new_pos_y);
            errors++;
          end
          if (result_ch.data.new_angle !== exp_r.new_angle) begin
            $error("new_angle exp %h got %h", exp_r.new_angle, result_ch.data.new_angle);
            errors++;
          end
        end
      end
      result_ch.ready <= (cyc > 3000 && cyc < 3800) || ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic drain();
    @(posedge clk);
    while (pending_bodies.size() != 0 || body_ch.valid || expected_updates.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DAMPING: damping_sh = longint'(val[15:0]);
      CFG_DT: dt_sh = longint'(val);
      CFG_GX: gx_sh = longint'($signed(val));
      CFG_GY: gy_sh = longint'($signed(val));
      CFG_QUIET: quiet_sh = val[0];
      default: ;
    endcase
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) queue_body(random_body());
    drain();
  endtask

  // stimulus sequence: directed bodies, then random phases over several settings
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // reset settings: divide by zero, extremes, every flag combination
    queue_body(mk(65536, 0, 0, 0, 4'h0));
    queue_body(mk(-65536, 0, 100, 5, 4'h0));
    queue_body(mk(0, 0, 0, 0, 4'h0));
    queue_body(mk(32'h7fffffff, 1, 32'h7fffffff, 32'h7fffffff, 4'h0));
    queue_body(mk(32'h80000000, 1, 32'h80000000, 32'h80000000, 4'h0));
    queue_body(mk(1, 32'hffffffff, -1, -1, 4'h0));
    for (int f = 0; f < 16; f++)
      queue_body(mk(131072, 65536, 65536, 1000, 4'(f)));
    drain();
    // damping on, unit time step: same-sign, opposing and zero-sum cases
    write_reg(CFG_DAMPING, 32'd32768);
    write_reg(CFG_DT, 32'd65536);
    queue_body(mk(65536, 65536, 65536, 0, 4'h8));
    queue_body(mk(65536, 65536, -655360, 0, 4'h8));
    queue_body(mk(131072, 65536, -65536, 0, 4'h8));
    run_random(300);
    write_reg(CFG_DAMPING, 32'd65535);
    write_reg(CFG_DT, 32'hffffffff);
    write_reg(CFG_GX, 32'h7fffffff);
    write_reg(CFG_GY, 32'h80000000);
    run_random(200);
    write_reg(CFG_DAMPING, 32'd0);
    write_reg(CFG_DT, 32'd0);
    write_reg(CFG_GX, 32'h80000000);
    write_reg(CFG_GY, 32'h7fffffff);
    run_random(150);
    write_reg(CFG_QUIET, 32'd1);
    write_reg(CFG_DT, 32'd655);
    run_random(200);
    write_reg(CFG_QUIET, 32'd0);
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_DAMPING, $urandom);
      write_reg(CFG_DT, $urandom_range(0, 200000));
      write_reg(CFG_GX, span(655360));
      write_reg(CFG_GY, span(655360));
      run_random(200);
    end
    repeat (80) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pli_pkg.sv
rtl/pli_stream_if.sv
rtl/pli_div.sv
rtl/particle_leapfrog_integrator_core.sv
tb/testbench.sv
